FILE: rtl/core/lpht_pkg.sv
// Package for the linear-probe hash table: request codes, slot modes,
// field widths and the stored slot word. No dependencies.
package lpht_pkg;

  // Field widths of the request and result items.
  localparam int unsigned KeyW  = 32;
  localparam int unsigned HashW = 32;
  localparam int unsigned ValW  = 64;
  localparam int unsigned FillW = 9;

  // Fill limit after reset.
  localparam logic [FillW-1:0] FillLimitRst = 9'd192;

  // Request codes.
  typedef logic [1:0] action_t;
  localparam action_t ActGet    = 2'd0;
  localparam action_t ActSet    = 2'd1;
  localparam action_t ActRemove = 2'd2;
  localparam action_t ActClear  = 2'd3;

  // Slot modes. The unused code is treated as a tombstone.
  typedef logic [1:0] mode_t;
  localparam mode_t ModeEmpty = 2'd0;
  localparam mode_t ModeFull  = 2'd1;
  localparam mode_t ModeTomb  = 2'd2;

  // One word of the slot memory: mode and key side by side.
  typedef struct packed {
    mode_t            mode;
    logic [KeyW-1:0]  key;
  } slot_t;

endpackage

FILE: rtl/core/linear_probe_hash_table.sv
// Linear-probe hash table with tombstones, held in two on-chip memories.
// Depends on lpht_pkg for codes, widths and the slot word type.
//
// Usage: a request item (action, key_handle, key_hash, value_in) is taken
// when in_valid_i is high and in_stall_o is low; in_stall_o is high whenever
// the block is busy with an item. Each request gives exactly one result item
// (hit, value_out, refused), offered on out_valid_o and taken when
// out_stall_i is low. The fill limit is written through the cfg channel,
// which is always ready.
// Probing: a get, set or remove reads its home slot at the accepting edge and
// then checks one slot per cycle, for a probe of 1 to SLOTS slots, reading
// each slot through the one read port of each memory. The next item is taken
// only after the result has been loaded. A clear sweeps the mode memory one
// slot per cycle and its result is loaded at the end of the sweep. After reset
// the same sweep runs, during which no item is accepted. While the receiver
// stalls, the result waits in the output register; a finished result that
// finds it full waits in a holding register and the block takes no new item
// until it is passed on.
module linear_probe_hash_table #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpht_pkg::FillW-1:0]    cfg_fill_limit_i,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lpht_pkg::action_t             action_i,
  input  logic [lpht_pkg::KeyW-1:0]     key_handle_i,
  input  logic [lpht_pkg::HashW-1:0]    key_hash_i,
  input  logic [lpht_pkg::ValW-1:0]     value_in_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o,
  output logic [lpht_pkg::ValW-1:0]     value_out_o,
  output logic                          refused_o
);
  import lpht_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_PUSH
  } state_e;

  // Control and request registers.
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              clear_req_q, clear_req_d;
  action_t           action_q, action_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              tomb_seen_q, tomb_seen_d;
  logic [AW-1:0]     tomb_at_q, tomb_at_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  limit_q, limit_d;

  // Holding and output registers.
  logic              res_hit_q, res_hit_d;
  logic [ValW-1:0]   res_val_q, res_val_d;
  logic              res_ref_q, res_ref_d;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic [ValW-1:0]   out_val_q, out_val_d;
  logic              out_ref_q, out_ref_d;

  // Memory ports.
  slot_t             slot_mem [SLOTS];
  logic [ValW-1:0]   val_mem  [SLOTS];
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  slot_t             rd_slot_q;
  logic [ValW-1:0]   rd_val_q;
  logic              slot_we;
  logic              val_we;
  logic [AW-1:0]     wr_addr;
  slot_t             wr_slot;

  // Probe decode and result loading.
  logic              cur_empty, cur_full, cur_match, cur_tomb, last_step, probe_end;
  logic              fill_ok;
  logic              out_free;
  logic              ld;
  logic              ld_hit;
  logic [ValW-1:0]   ld_val;
  logic              ld_ref;

  assign cur_empty = (rd_slot_q.mode == ModeEmpty);
  assign cur_full  = (rd_slot_q.mode == ModeFull);
  assign cur_match = cur_full && (rd_slot_q.key == key_q);
  assign cur_tomb  = !cur_empty && !cur_full;
  assign last_step = (cnt_q == AW'(SLOTS - 1));
  assign probe_end = cur_empty || cur_match || last_step;
  assign fill_ok   = (({1'b0, fill_q} + 10'd1) <= {1'b0, limit_q});
  assign out_free  = !out_valid_q || !out_stall_i;

  // Next-state logic of the request sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    clear_req_d = clear_req_q;
    action_d    = action_q;
    key_d       = key_q;
    val_d       = val_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    tomb_seen_d = tomb_seen_q;
    tomb_at_d   = tomb_at_q;
    fill_d      = fill_q;
    limit_d     = cfg_valid_i ? cfg_fill_limit_i : limit_q;
    res_hit_d   = res_hit_q;
    res_val_d   = res_val_q;
    res_ref_d   = res_ref_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hit_d   = out_hit_q;
    out_val_d   = out_val_q;
    out_ref_d   = out_ref_q;
    rd_en       = 1'b0;
    rd_addr     = pos_q + 1'b1;
    slot_we     = 1'b0;
    val_we      = 1'b0;
    wr_addr     = pos_q;
    wr_slot     = '{mode: ModeFull, key: key_q};
    ld          = 1'b0;
    ld_hit      = 1'b0;
    ld_val      = '0;
    ld_ref      = 1'b0;

    case (state_q)
      // Sweep the mode memory to empty, one slot per cycle.
      ST_CLEAR: begin
        slot_we = 1'b1;
        wr_addr = clr_q;
        wr_slot = '{mode: ModeEmpty, key: key_q};
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(SLOTS - 1)) begin
          fill_d      = '0;
          clear_req_d = 1'b0;
          if (clear_req_q) begin
            ld = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      // Take a request item and, unless it is a clear, issue the read of its home slot.
      ST_IDLE: begin
        if (in_valid_i) begin
          action_d    = action_i;
          key_d       = key_handle_i;
          val_d       = value_in_i;
          pos_d       = key_hash_i[AW-1:0];
          cnt_d       = '0;
          tomb_seen_d = 1'b0;
          if (action_i == ActClear) begin
            clr_d       = '0;
            clear_req_d = 1'b1;
            state_d     = ST_CLEAR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = key_hash_i[AW-1:0];
            state_d = ST_PROBE;
          end
        end
      end

      // Check one slot per cycle while the next one is being read.
      ST_PROBE: begin
        if (!probe_end) begin
          rd_en = 1'b1;
          pos_d = pos_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (cur_tomb && !tomb_seen_q) begin
            tomb_seen_d = 1'b1;
            tomb_at_d   = pos_q;
          end
        end else begin
          ld = 1'b1;
          case (action_q)
            ActGet: begin
              ld_hit = cur_match;
              ld_val = cur_match ? rd_val_q : '0;
            end
            ActRemove: begin
              ld_hit = cur_match;
              if (cur_match) begin
                slot_we = 1'b1;
                wr_slot = '{mode: ModeTomb, key: rd_slot_q.key};
              end
            end
            ActSet: begin
              if (cur_match) begin
                // Key present: overwrite the value only.
                val_we = 1'b1;
              end else if (tomb_seen_q || cur_tomb) begin
                // Reuse the first tombstone the probe passed.
                slot_we = 1'b1;
                val_we  = 1'b1;
                wr_addr = tomb_seen_q ? tomb_at_q : pos_q;
                ld_hit  = 1'b1;
              end else if (cur_empty && fill_ok) begin
                slot_we = 1'b1;
                val_we  = 1'b1;
                fill_d  = fill_q + 1'b1;
                ld_hit  = 1'b1;
              end else begin
                ld_ref = 1'b1;
              end
            end
            default: begin
              ld_hit = 1'b0;
            end
          endcase
        end
      end

      // Pass a held result on once the output register is free.
      ST_PUSH: begin
        ld     = 1'b1;
        ld_hit = res_hit_q;
        ld_val = res_val_q;
        ld_ref = res_ref_q;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Load a finished result into the output register or hold it.
    if (ld) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        out_hit_d   = ld_hit;
        out_val_d   = ld_val;
        out_ref_d   = ld_ref;
        state_d     = ST_IDLE;
      end else begin
        res_hit_d = ld_hit;
        res_val_d = ld_val;
        res_ref_d = ld_ref;
        state_d   = ST_PUSH;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      clear_req_q <= 1'b0;
      action_q    <= ActGet;
      key_q       <= '0;
      val_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      tomb_seen_q <= 1'b0;
      tomb_at_q   <= '0;
      fill_q      <= '0;
      limit_q     <= FillLimitRst;
      res_hit_q   <= 1'b0;
      res_val_q   <= '0;
      res_ref_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_val_q   <= '0;
      out_ref_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clear_req_q <= clear_req_d;
      action_q    <= action_d;
      key_q       <= key_d;
      val_q       <= val_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      tomb_seen_q <= tomb_seen_d;
      tomb_at_q   <= tomb_at_d;
      fill_q      <= fill_d;
      limit_q     <= limit_d;
      res_hit_q   <= res_hit_d;
      res_val_q   <= res_val_d;
      res_ref_q   <= res_ref_d;
      out_valid_q <= out_valid_d;
      out_hit_q   <= out_hit_d;
      out_val_q   <= out_val_d;
      out_ref_q   <= out_ref_d;
    end
  end

  // Slot memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[wr_addr] <= wr_slot;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_slot_q <= slot_mem[rd_addr];
      rd_val_q  <= val_mem[rd_addr];
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign value_out_o = out_val_q;
  assign refused_o   = out_ref_q;

  // The probe never runs past its last slot.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE && last_step) |=> (state_q != ST_PROBE))
    else $error("probe ran past the last slot");

  // The fill count only steps up by one or drops to zero on a clear.
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ((fill_q == $past(fill_q) + 1'b1) || (fill_q == '0)))
    else $error("fill count changed by more than one");

  // A refused set reports neither a hit nor a value.
  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && refused_o) |-> (!hit_o && (value_out_o == '0)))
    else $error("refused result carries a hit or a value");

endmodule

FILE: sim/lpht_checker.sv
// Checker for the linear-probe hash table: watches the config, request and result channels,
// keeps its own copy of the table, predicts each result and compares it.
// Depends on lpht_pkg for request codes, slot modes and field widths.
module lpht_checker #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [lpht_pkg::FillW-1:0] cfg_fill_limit_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  lpht_pkg::action_t          action_i,
  input  logic [lpht_pkg::KeyW-1:0]  key_handle_i,
  input  logic [lpht_pkg::HashW-1:0] key_hash_i,
  input  logic [lpht_pkg::ValW-1:0]  value_in_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       hit_i,
  input  logic [lpht_pkg::ValW-1:0]  value_out_i,
  input  logic                       refused_i,
  output int unsigned                fail_cnt_o,
  output int unsigned                pending_o,
  output int unsigned                checked_o,
  output int unsigned                hits_o,
  output int unsigned                refusals_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int unsigned MaxReports = 200;

  // One predicted result item.
  typedef struct packed {
    logic            hit;
    logic [ValW-1:0] value;
    logic            refused;
  } answer_t;

  answer_t answers_q[$];

  // Shadow copy of the table and its fill state.
  logic [KeyW-1:0]  tbl_key [SLOTS];
  logic [ValW-1:0]  tbl_val [SLOTS];
  mode_t            tbl_mode[SLOTS];
  int unsigned      used_slots;
  logic [FillW-1:0] limit_q;

  // Apply one request to the shadow table and return the result it should give.
  function automatic answer_t serve_request(action_t act, logic [KeyW-1:0] key,
                                            logic [HashW-1:0] hash, logic [ValW-1:0] val);
    int unsigned pos;
    int unsigned n;
    int unsigned found_at;
    int unsigned empty_at;
    int unsigned tomb_at;
    bit          found;
    bit          has_empty;
    bit          has_tomb;
    answer_t     ans;
    ans       = '0;
    found     = 1'b0;
    has_empty = 1'b0;
    has_tomb  = 1'b0;
    found_at  = 0;
    empty_at  = 0;
    tomb_at   = 0;
    if (act == ActClear) begin
      for (int i = 0; i < SLOTS; i++) tbl_mode[i] = ModeEmpty;
      used_slots = 0;
      return ans;
    end
    // Walk from the home slot until the key or a truly empty slot turns up.
    pos = hash & (SLOTS - 1);
    for (n = 0; n < SLOTS && !found && !has_empty; n++) begin
      if (tbl_mode[pos] == ModeEmpty) begin
        has_empty = 1'b1;
        empty_at  = pos;
      end else if (tbl_mode[pos] == ModeFull) begin
        if (tbl_key[pos] == key) begin
          found    = 1'b1;
          found_at = pos;
        end
      end else if (!has_tomb) begin
        // Tombstones and the unused mode code both count as tombstones.
        has_tomb = 1'b1;
        tomb_at  = pos;
      end
      pos = (pos + 1) & (SLOTS - 1);
    end
    case (act)
      ActGet: begin
        if (found) begin
          ans.hit   = 1'b1;
          ans.value = tbl_val[found_at];
        end
      end
      ActRemove: begin
        if (found) begin
          tbl_mode[found_at] = ModeTomb;
          ans.hit            = 1'b1;
        end
      end
      default: begin
        if (found) begin
          // Overwrite of a present key never changes the fill count.
          tbl_val[found_at] = val;
        end else if (has_tomb) begin
          tbl_mode[tomb_at] = ModeFull;
          tbl_key[tomb_at]  = key;
          tbl_val[tomb_at]  = val;
          ans.hit           = 1'b1;
        end else if (has_empty && used_slots + 1 <= limit_q) begin
          tbl_mode[empty_at] = ModeFull;
          tbl_key[empty_at]  = key;
          tbl_val[empty_at]  = val;
          used_slots         = used_slots + 1;
          ans.hit            = 1'b1;
        end else begin
          ans.refused = 1'b1;
        end
      end
    endcase
    return ans;
  endfunction

  // Count a failure and print it while the report budget lasts.
  task automatic report(string field, logic [ValW-1:0] exp_v, logic [ValW-1:0] act_v);
    if (fail_cnt_o < MaxReports) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
    end
    fail_cnt_o++;
  endtask

  // Compare one accepted result item with the oldest prediction.
  task automatic check_answer();
    answer_t exp_a;
    if (answers_q.size() == 0) begin
      report("unexpected result item", '0, {hit_i, refused_i});
    end else begin
      exp_a = answers_q.pop_front();
      checked_o++;
      if (exp_a.hit) hits_o++;
      if (exp_a.refused) refusals_o++;
      if (hit_i !== exp_a.hit) report("hit", exp_a.hit, hit_i);
      if (value_out_i !== exp_a.value) report("value_out", exp_a.value, value_out_i);
      if (refused_i !== exp_a.refused) report("refused", exp_a.refused, refused_i);
    end
  endtask

  // Results are taken before requests, so a result never meets its own request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answers_q.delete();
      for (int i = 0; i < SLOTS; i++) tbl_mode[i] = ModeEmpty;
      used_slots = 0;
      limit_q    = FillLimitRst;
      fail_cnt_o = 0;
      pending_o  = 0;
      checked_o  = 0;
      hits_o     = 0;
      refusals_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_answer();
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_fill_limit_i;
      if (in_valid_i && !in_stall_i) begin
        answers_q.push_back(serve_request(action_i, key_handle_i, key_hash_i, value_in_i));
      end
      pending_o = answers_q.size();
    end
  end

endmodule

FILE: sim/tb_linear_probe_hash_table.sv
// Testbench top for the linear-probe hash table: clock, reset, request and stall stimulus,
// fill-limit phases and the verdict. Depends on lpht_pkg, the block and lpht_checker.
module tb_linear_probe_hash_table;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam int unsigned TableSlots = 256;
  localparam int unsigned ClkPeriod  = 20;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned PoolSize   = 512;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             cfg_valid_i      = 1'b0;
  logic             cfg_ready_o;
  logic [FillW-1:0] cfg_fill_limit_i = '0;
  logic             in_valid_i       = 1'b0;
  logic             in_stall_o;
  action_t          action_i         = ActGet;
  logic [KeyW-1:0]  key_handle_i     = '0;
  logic [HashW-1:0] key_hash_i       = '0;
  logic [ValW-1:0]  value_in_i       = '0;
  logic             out_valid_o;
  logic             out_stall_i      = 1'b0;
  logic             hit_o;
  logic [ValW-1:0]  value_out_o;
  logic             refused_o;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;
  int unsigned hit_cnt;
  int unsigned refusal_cnt;

  int unsigned      idle_cycles = 0;
  int unsigned      stall_left  = 0;
  logic             calm        = 1'b0;
  int unsigned      sent_cnt    = 0;
  int unsigned      phase_cnt   = 0;
  logic [KeyW-1:0]  key_pool [PoolSize];
  logic [HashW-1:0] hash_pool[PoolSize];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  linear_probe_hash_table #(
    .SLOTS(TableSlots)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_fill_limit_i(cfg_fill_limit_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .key_handle_i    (key_handle_i),
    .key_hash_i      (key_hash_i),
    .value_in_i      (value_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .value_out_o     (value_out_o),
    .refused_o       (refused_o)
  );

  lpht_checker #(
    .SLOTS(TableSlots)
  ) u_chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_fill_limit_i(cfg_fill_limit_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .key_handle_i    (key_handle_i),
    .key_hash_i      (key_hash_i),
    .value_in_i      (value_in_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_i           (hit_o),
    .value_out_i     (value_out_o),
    .refused_i       (refused_o),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending_cnt),
    .checked_o       (checked_cnt),
    .hits_o          (hit_cnt),
    .refusals_o      (refusal_cnt)
  );

  // Gap length for either side: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Value word with the all-zero and all-one extremes mixed in.
  function automatic logic [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Receiver stall: random stretches of back-pressure, no new stretch while calm.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles in which no item moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no item moved for %0d cycles", IdleLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request item and hold it until the block takes it.
  task automatic send_req(action_t act, logic [KeyW-1:0] key, logic [HashW-1:0] hash,
                          logic [ValW-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    key_handle_i <= key;
    key_hash_i   <= hash;
    value_in_i   <= val;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Write the fill limit while the block is idle.
  task automatic write_limit(logic [FillW-1:0] limit);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_fill_limit_i <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    phase_cnt++;
  endtask

  // One phase of random traffic under a given limit. A phase may start by inserting
  // the first pool keys so that the table fills up completely.
  task automatic run_phase(logic [FillW-1:0] limit, int unsigned count, int unsigned pool_n,
                           int unsigned prefill, int unsigned w_get, int unsigned w_set,
                           int unsigned w_rem, int unsigned clr_permille);
    int unsigned     idx;
    int unsigned     r;
    action_t         act;
    logic [KeyW-1:0]  key;
    logic [HashW-1:0] hash;
    write_limit(limit);
    for (int i = 0; i < prefill; i++) begin
      send_req(ActSet, key_pool[i], hash_pool[i], pick_value());
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) drain();
      if ($urandom_range(0, 49) == 0) calm <= ~calm;
      if ($urandom_range(0, 999) < clr_permille) begin
        act = ActClear;
      end else begin
        r = $urandom_range(0, w_get + w_set + w_rem - 1);
        if (r < w_get) act = ActGet;
        else if (r < w_get + w_set) act = ActSet;
        else act = ActRemove;
      end
      idx  = $urandom_range(0, pool_n - 1);
      key  = key_pool[idx];
      hash = hash_pool[idx];
      // A share of noise: unknown keys, and known keys under a wrong hash.
      r = $urandom_range(0, 99);
      if (r < 6) begin
        key  = $urandom;
        hash = $urandom;
      end else if (r < 9) begin
        hash = $urandom;
      end
      send_req(act, key, hash, pick_value());
    end
  endtask

  initial begin
    int unsigned fails;
    // Key pool; half of the hashes crowd onto a few home slots to force long probes.
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i]  = $urandom;
      hash_pool[i] = $urandom;
      if (i % 2 == 1) hash_pool[i][7:0] = 8'($urandom_range(0, 7) * 5);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset limit.
    write_limit(FillLimitRst);
    send_req(ActGet,    32'h0000_00A1, 32'h1234_5605, '1);
    send_req(ActSet,    32'h0000_00A1, 32'h1234_5605, '1);
    send_req(ActGet,    32'h0000_00A1, 32'h1234_5605, '0);
    send_req(ActSet,    32'h0000_00A1, 32'h1234_5605, '0);
    send_req(ActGet,    32'h0000_00A1, 32'h1234_5605, '1);
    // A second key on the same home slot walks one slot further.
    send_req(ActSet,    32'h0000_00B2, 32'hABCD_0005, 64'h0123_4567_89AB_CDEF);
    send_req(ActGet,    32'h0000_00B2, 32'hABCD_0005, '0);
    send_req(ActRemove, 32'h0000_00A1, 32'h1234_5605, '0);
    send_req(ActGet,    32'h0000_00A1, 32'h1234_5605, '0);
    send_req(ActGet,    32'h0000_00B2, 32'hABCD_0005, '0);
    send_req(ActRemove, 32'h0000_00A1, 32'h1234_5605, '0);
    // A new key on that home slot takes over the tombstone.
    send_req(ActSet,    32'h0000_00C3, 32'h0000_0105, 64'h8000_0000_0000_0001);
    send_req(ActGet,    32'h0000_00C3, 32'h0000_0105, '0);
    // Last slot, then a probe that wraps around to slot zero.
    send_req(ActSet,    32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send_req(ActSet,    32'h0000_00E5, 32'h0000_00FF, 64'hFEDC_BA98_7654_3210);
    send_req(ActGet,    32'h0000_00E5, 32'h0000_00FF, '0);
    send_req(ActGet,    32'h0000_0000, 32'h0000_0000, '0);
    send_req(ActSet,    32'h0000_0000, 32'h0000_0000, 64'h8000_0000_0000_0000);
    send_req(ActGet,    32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_req(ActClear,  32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send_req(ActGet,    32'h0000_00B2, 32'hABCD_0005, '0);
    send_req(ActSet,    32'h0000_00B2, 32'hABCD_0005, 64'h5555_AAAA_5555_AAAA);
    send_req(ActGet,    32'h0000_00B2, 32'hABCD_0005, '0);

    // Random phases: tight limit, zero limit with tombstones left over, a completely
    // full table, a limit equal to the capacity, a random limit and a limit of one.
    run_phase(9'd8,   250, 16,  0,   35, 45, 15, 8);
    run_phase(9'd0,   150, 16,  0,   40, 40, 20, 0);
    run_phase(9'd511, 200, 300, 270, 40, 35, 25, 0);
    run_phase(9'd256, 150, 300, 0,   40, 30, 30, 0);
    run_phase(9'($urandom_range(1, 255)), 300, 120, 0, 40, 40, 20, 10);
    run_phase(9'd1,   80,  8,   0,   30, 50, 20, 30);

    // Let the last results through, then give the block time to settle.
    drain();
    repeat (2 * TableSlots + 8) @(posedge clk_i);
    if (pending_cnt != 0) $error("%0d predicted results never arrived", pending_cnt);
    fails = fail_cnt + pending_cnt;
    $display("Summary: %0d requests over %0d fill-limit settings, %0d results checked",
             sent_cnt, phase_cnt, checked_cnt);
    $display("Summary: %0d hits, %0d refused sets, %0d failures", hit_cnt, refusal_cnt, fails);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
